>>> hdl/kmeg_pkg.sv
// ----------------------------------------------------------------------------
// Key matrix event generator package
// Shared payload types, control groups, register indexes and the keymap ROMs.
// ----------------------------------------------------------------------------
package kmeg_pkg;

  // Fixed geometry of the snapshot and of the keymap tables.
  localparam int MATRIX_BITS = 56;
  localparam int CNT_W       = 6;
  localparam int MAP_ROWS    = 8;
  localparam int MAP_COLS    = 7;

  // Key codes with a meaning of their own.
  localparam logic [7:0] CODE_NONE    = 8'h00;
  localparam logic [7:0] CODE_FN      = 8'hF0;
  localparam logic [7:0] CODE_SPECIAL = 8'hF0;

  // Configuration register indexes.
  localparam logic [1:0] REG_DEBOUNCE_INTERVAL = 2'd0;
  localparam logic [1:0] REG_REPEAT_ENABLE     = 2'd1;
  localparam logic [1:0] REG_REPEAT_DELAY      = 2'd2;
  localparam logic [1:0] REG_REPEAT_PERIOD     = 2'd3;

  // Configuration reset values.
  localparam logic [15:0] DEBOUNCE_RESET = 16'd20;
  localparam logic [15:0] DELAY_RESET    = 16'd500;
  localparam logic [15:0] PERIOD_RESET   = 16'd50;

  // One polling pass.
  typedef struct packed {
    logic [31:0]            now_ms;
    logic [MATRIX_BITS-1:0] key_matrix;
  } input_t;

  // One key event as it leaves the block.
  typedef struct packed {
    logic [7:0] key_code;
    logic [2:0] modifier_bits;
    logic       is_press;
    logic       special_key;
    logic       last_of_run;
  } result_t;

  // An event before its run position is known.
  typedef struct packed {
    logic [7:0] key_code;
    logic [2:0] modifier_bits;
    logic       is_press;
  } event_t;

  // Candidate produced by the serial matrix walk for the current position.
  typedef struct packed {
    logic       valid;
    logic [7:0] code;
    logic       press;
  } scan_cand_t;

  // Control of the serial matrix walk.
  typedef struct packed {
    logic load;
    logic step;
  } scan_ctrl_t;

  // Control and status of the output buffer.
  typedef struct packed {
    logic push;
    logic flush;
  } ob_ctrl_t;

  typedef struct packed {
    logic stall;
    logic flush_done;
  } ob_stat_t;

  // Normal keymap, row-major.
  localparam logic [7:0] MAP_PLAIN [MAP_ROWS][MAP_COLS] = '{
    '{8'h35, 8'h1E, 8'h1F, 8'h20, 8'h21, 8'h22, 8'h23},
    '{8'h24, 8'h25, 8'h26, 8'h27, 8'h2D, 8'h2E, 8'h2A},
    '{8'h2B, 8'h14, 8'h1A, 8'h08, 8'h15, 8'h17, 8'h1C},
    '{8'h18, 8'h0C, 8'h12, 8'h13, 8'h2F, 8'h30, 8'h31},
    '{8'hF0, 8'h04, 8'h16, 8'h07, 8'h09, 8'h0A, 8'h0B},
    '{8'h0D, 8'h0E, 8'h0F, 8'h33, 8'h34, 8'h28, 8'h00},
    '{8'h00, 8'h1D, 8'h1B, 8'h06, 8'h19, 8'h05, 8'h11},
    '{8'h10, 8'h36, 8'h37, 8'h38, 8'h00, 8'h2C, 8'h00}
  };

  // FN layer; an empty entry falls back to the normal keymap.
  localparam logic [7:0] MAP_FN [MAP_ROWS][MAP_COLS] = '{
    '{8'h29, 8'h3A, 8'h3B, 8'h3C, 8'h3D, 8'h3E, 8'h3F},
    '{8'h40, 8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h4C},
    '{8'h00, 8'h00, 8'h52, 8'h00, 8'h00, 8'h00, 8'h4A},
    '{8'h4D, 8'h00, 8'h00, 8'h4B, 8'h00, 8'h00, 8'h00},
    '{8'hF0, 8'h50, 8'h51, 8'h4F, 8'h4E, 8'h00, 8'h00},
    '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'hF1, 8'hF2, 8'hF3, 8'h00, 8'h00, 8'h00, 8'h00}
  };

  // Keymap lookup. Modifier positions and the column beyond the table are empty.
  function automatic logic [7:0] keymap_lookup(input logic [2:0] row,
                                               input logic [2:0] col,
                                               input logic       fn);
    logic       is_mod;
    logic [7:0] code;
    is_mod = (row == 3'd6 && col == 3'd0) || (row == 3'd7 && col == 3'd4) ||
             (row == 3'd7 && col == 3'd6);
    code = CODE_NONE;
    if (col != 3'd7 && !is_mod) begin
      if (fn && MAP_FN[row][col] != CODE_NONE) begin
        code = MAP_FN[row][col];
      end else begin
        code = MAP_PLAIN[row][col];
      end
    end
    return code;
  endfunction

endpackage

>>> hdl/key_matrix_event_generator.sv
// ----------------------------------------------------------------------------
// Key matrix event generator
// Debounced key matrix scanner with FN layer, modifiers and auto-repeat.
// ----------------------------------------------------------------------------
// One polling pass is taken at a time. A pass that fails the debounce check
// skips the walk; an accepted pass walks the 56-bit snapshot one bit per
// cycle through a serial shift register, stalling while an event finds the
// output register full. Events leave in row-major key order, any auto-repeat
// press last, and the final event of a pass carries last_of_run. The next pass
// is taken once the last event of the previous one sits in the output register.
module key_matrix_event_generator #(
  parameter int ROWS = 8,
  parameter int COLS = 7
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  kmeg_pkg::input_t     in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output kmeg_pkg::result_t    out_data,
  input  logic                 cfg_write,
  input  logic [1:0]           cfg_index,
  input  logic [15:0]          cfg_data
);

  // Fixed key positions, present only when the matrix reaches them.
  localparam bit CTRL_OK  = (7 < ROWS) && (4 < COLS) && (7 * COLS + 4 < 56);
  localparam bit SHIFT_OK = (6 < ROWS) && (0 < COLS) && (6 * COLS < 56);
  localparam bit ALT_OK   = (7 < ROWS) && (6 < COLS) && (7 * COLS + 6 < 56);
  localparam bit FN_OK    = (4 < ROWS) && (0 < COLS) && (4 * COLS < 56);
  localparam int CTRL_IDX  = CTRL_OK  ? 7 * COLS + 4 : 0;
  localparam int SHIFT_IDX = SHIFT_OK ? 6 * COLS     : 0;
  localparam int ALT_IDX   = ALT_OK   ? 7 * COLS + 6 : 0;
  localparam int FN_IDX    = FN_OK    ? 4 * COLS     : 0;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SCAN,
    ST_REP_DELAY,
    ST_REP_PERIOD,
    ST_FLUSH
  } state_t;

  state_t state;

  // Configuration registers.
  logic [15:0] debounce_interval;
  logic        repeat_enable;
  logic [15:0] repeat_delay;
  logic [15:0] repeat_period;

  // Pass state.
  kmeg_pkg::input_t in_reg;
  logic [31:0]      last_accept_time;
  logic             fn_held;
  logic [2:0]       held_modifiers;
  logic [7:0]       repeating_code;
  logic [31:0]      repeat_start;
  logic [31:0]      last_repeat_stamp;

  kmeg_pkg::scan_ctrl_t scan_ctrl;
  kmeg_pkg::scan_cand_t cand;
  logic                 last_pos;
  kmeg_pkg::ob_ctrl_t   ob_ctrl;
  kmeg_pkg::ob_stat_t   ob_stat;
  kmeg_pkg::event_t     push_ev;

  logic [2:0]  mods_now;
  logic        fn_now;
  logic        debounce_ok;
  logic        delay_ok;
  logic        period_ok;
  logic        scan_push;
  logic        rep_push;

  // Handshake, timer compares and event selection.
  always_comb begin
    in_ready    = state == ST_IDLE;
    mods_now    = {ALT_OK   && in_reg.key_matrix[ALT_IDX[5:0]],
                   SHIFT_OK && in_reg.key_matrix[SHIFT_IDX[5:0]],
                   CTRL_OK  && in_reg.key_matrix[CTRL_IDX[5:0]]};
    fn_now      = FN_OK && in_reg.key_matrix[FN_IDX[5:0]];
    debounce_ok = (in_reg.now_ms - last_accept_time) >= {16'd0, debounce_interval};
    delay_ok    = repeat_enable && (repeating_code != kmeg_pkg::CODE_NONE) &&
                  ((in_reg.now_ms - repeat_start) >= {16'd0, repeat_delay});
    period_ok   = (last_repeat_stamp == 32'd0) ||
                  ((in_reg.now_ms - last_repeat_stamp) >= {16'd0, repeat_period});

    scan_ctrl.load = in_valid && in_ready;
    scan_ctrl.step = (state == ST_SCAN) && !(cand.valid && ob_stat.stall);
    scan_push      = scan_ctrl.step && cand.valid;
    rep_push       = (state == ST_REP_PERIOD) && period_ok && !ob_stat.stall;

    ob_ctrl.push  = scan_push || rep_push;
    ob_ctrl.flush = state == ST_FLUSH;

    if (state == ST_SCAN) begin
      push_ev = '{key_code: cand.code, modifier_bits: held_modifiers,
                  is_press: cand.press};
    end else begin
      push_ev = '{key_code: repeating_code, modifier_bits: held_modifiers,
                  is_press: 1'b1};
    end
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_interval <= kmeg_pkg::DEBOUNCE_RESET;
      repeat_enable     <= 1'b1;
      repeat_delay      <= kmeg_pkg::DELAY_RESET;
      repeat_period     <= kmeg_pkg::PERIOD_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        kmeg_pkg::REG_DEBOUNCE_INTERVAL: debounce_interval <= cfg_data;
        kmeg_pkg::REG_REPEAT_ENABLE:     repeat_enable     <= cfg_data[0];
        kmeg_pkg::REG_REPEAT_DELAY:      repeat_delay      <= cfg_data;
        kmeg_pkg::REG_REPEAT_PERIOD:     repeat_period     <= cfg_data;
        default: ;
      endcase
    end
  end

  // Captured polling pass.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_reg <= in_data;
    end
  end

  // Pass sequencer with debounce, modifier and auto-repeat state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= ST_IDLE;
      last_accept_time  <= '0;
      fn_held           <= 1'b0;
      held_modifiers    <= '0;
      repeating_code    <= kmeg_pkg::CODE_NONE;
      repeat_start      <= '0;
      last_repeat_stamp <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            state <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          if (debounce_ok) begin
            held_modifiers   <= mods_now;
            fn_held          <= fn_now;
            last_accept_time <= in_reg.now_ms;
            state            <= ST_SCAN;
          end else begin
            state <= ST_REP_DELAY;
          end
        end
        ST_SCAN: begin
          if (scan_push) begin
            if (cand.press && repeat_enable) begin
              repeating_code    <= cand.code;
              repeat_start      <= in_reg.now_ms;
              last_repeat_stamp <= '0;
            end else if (!cand.press && cand.code == repeating_code) begin
              repeating_code <= kmeg_pkg::CODE_NONE;
            end
          end
          if (scan_ctrl.step && last_pos) begin
            state <= ST_REP_DELAY;
          end
        end
        ST_REP_DELAY: begin
          state <= delay_ok ? ST_REP_PERIOD : ST_FLUSH;
        end
        ST_REP_PERIOD: begin
          if (!period_ok) begin
            state <= ST_FLUSH;
          end else if (rep_push) begin
            last_repeat_stamp <= in_reg.now_ms;
            state             <= ST_FLUSH;
          end
        end
        ST_FLUSH: begin
          if (ob_stat.flush_done) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  kmeg_scan #(
    .ROWS (ROWS),
    .COLS (COLS)
  ) u_scan (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (scan_ctrl),
    .matrix   (in_data.key_matrix),
    .fn       (fn_held),
    .cand     (cand),
    .last_pos (last_pos)
  );

  kmeg_outbuf u_outbuf (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (ob_ctrl),
    .push_ev   (push_ev),
    .stat      (ob_stat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // An event is never pushed while the held event cannot move out.
  a_no_push_on_stall: assert property (@(posedge clk) disable iff (rst)
    !(ob_ctrl.push && ob_stat.stall))
    else $error("event pushed while output buffer stalled");

  // Between passes no event is held back.
  a_idle_buffer_empty: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> !ob_stat.stall)
    else $error("held event left over between passes");

  // Only one pass is in work at a time.
  a_one_pass: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("new pass taken while one is in work");

  // The FN key itself never becomes the repeating key.
  a_no_fn_repeat: assert property (@(posedge clk) disable iff (rst)
    repeating_code != kmeg_pkg::CODE_FN)
    else $error("FN code selected for auto-repeat");

endmodule

>>> hdl/kmeg_scan.sv
// ----------------------------------------------------------------------------
// Key matrix serial walk
// Shifts the new and previous snapshots one bit per cycle while stepped and
// looks up the key event for the position under the head.
// ----------------------------------------------------------------------------
module kmeg_scan #(
  parameter int ROWS = 8,
  parameter int COLS = 7
) (
  input  logic                                clk,
  input  logic                                rst,
  input  kmeg_pkg::scan_ctrl_t                ctrl,
  input  logic [kmeg_pkg::MATRIX_BITS-1:0]    matrix,
  input  logic                                fn,
  output kmeg_pkg::scan_cand_t                cand,
  output logic                                last_pos
);

  localparam int                    POS_COUNT = ROWS * COLS;
  localparam logic [2:0]            COL_LAST  = 3'(COLS - 1);
  localparam logic [kmeg_pkg::CNT_W-1:0] CNT_LAST =
    kmeg_pkg::CNT_W'(kmeg_pkg::MATRIX_BITS - 1);

  logic [kmeg_pkg::MATRIX_BITS-1:0] cur_sh;
  logic [kmeg_pkg::MATRIX_BITS-1:0] prev_sh;
  logic [kmeg_pkg::CNT_W-1:0]       bit_cnt;
  logic [2:0]                       row;
  logic [2:0]                       col;
  logic                             pos_valid;
  logic [7:0]                       code;

  // Event candidate for the current position.
  always_comb begin
    pos_valid  = 32'(bit_cnt) < POS_COUNT;
    code       = kmeg_pkg::keymap_lookup(row, col, fn);
    cand.valid = pos_valid && (cur_sh[0] != prev_sh[0]) &&
                 (code != kmeg_pkg::CODE_NONE) && (code != kmeg_pkg::CODE_FN);
    cand.code  = code;
    cand.press = cur_sh[0];
    last_pos   = bit_cnt == CNT_LAST;
  end

  // Previous snapshot and position counters. The new snapshot shifts into the
  // previous one, so after a full walk it holds the accepted snapshot.
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_sh <= '0;
      bit_cnt <= '0;
      row     <= '0;
      col     <= '0;
    end else if (ctrl.load) begin
      bit_cnt <= '0;
      row     <= '0;
      col     <= '0;
    end else if (ctrl.step) begin
      prev_sh <= {cur_sh[0], prev_sh[kmeg_pkg::MATRIX_BITS-1:1]};
      bit_cnt <= bit_cnt + 1'b1;
      if (col == COL_LAST) begin
        col <= '0;
        row <= row + 1'b1;
      end else begin
        col <= col + 1'b1;
      end
    end
  end

  // New snapshot shift register.
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      cur_sh <= matrix;
    end else if (ctrl.step) begin
      cur_sh <= {1'b0, cur_sh[kmeg_pkg::MATRIX_BITS-1:1]};
    end
  end

endmodule

>>> hdl/kmeg_outbuf.sv
// ----------------------------------------------------------------------------
// Key event output buffer
// Holds one event back until the next one, or the end of the pass, shows
// whether it closes the run, then presents it in the output register.
// ----------------------------------------------------------------------------
module kmeg_outbuf (
  input  logic                  clk,
  input  logic                  rst,
  input  kmeg_pkg::ob_ctrl_t    ctrl,
  input  kmeg_pkg::event_t      push_ev,
  output kmeg_pkg::ob_stat_t    stat,
  output logic                  out_valid,
  input  logic                  out_ready,
  output kmeg_pkg::result_t     out_data
);

  kmeg_pkg::event_t pend;
  logic             pend_valid;
  logic             push_ok;

  // The output register can take a new event when empty or being drained.
  always_comb begin
    push_ok         = !out_valid || out_ready;
    stat.stall      = pend_valid && !push_ok;
    stat.flush_done = ctrl.flush && (!pend_valid || push_ok);
  end

  // Control: pending and output valid flags.
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if ((ctrl.push && pend_valid) || (ctrl.flush && pend_valid && push_ok)) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (ctrl.push) begin
        pend_valid <= 1'b1;
      end else if (ctrl.flush && pend_valid && push_ok) begin
        pend_valid <= 1'b0;
      end
    end
  end

  // Payload: the held event moves out, marked last only on a flush.
  always_ff @(posedge clk) begin
    if (ctrl.push) begin
      if (pend_valid) begin
        out_data <= '{key_code:      pend.key_code,
                      modifier_bits: pend.modifier_bits,
                      is_press:      pend.is_press,
                      special_key:   pend.key_code >= kmeg_pkg::CODE_SPECIAL,
                      last_of_run:   1'b0};
      end
      pend <= push_ev;
    end else if (ctrl.flush && pend_valid && push_ok) begin
      out_data <= '{key_code:      pend.key_code,
                    modifier_bits: pend.modifier_bits,
                    is_press:      pend.is_press,
                    special_key:   pend.key_code >= kmeg_pkg::CODE_SPECIAL,
                    last_of_run:   1'b1};
    end
  end

endmodule

>>> dv/key_matrix_event_generator_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Key matrix event generator testbench
// Drives polling passes through the input channel and predicts the key events
// (debounce, modifiers, FN layer, auto-repeat) with a scoreboard of its own.
// Every event leaving the block is checked field by field, in order, against
// the predicted stream. Configuration changes happen only between phases.
// ----------------------------------------------------------------------------
module key_matrix_event_generator_test;

  // Special key positions as bit indexes of the snapshot.
  localparam int FN_BIT    = 28;
  localparam int SHIFT_BIT = 42;
  localparam int CTRL_BIT  = 53;
  localparam int ALT_BIT   = 55;

  localparam int SETTLE_CYCLES = 100;
  localparam int LONG_HOLD     = 400;
  localparam int LIMIT_NS      = 15_000_000;

  // Keymaps in row-major order, index 0 first.
  localparam logic [0:55][7:0] PLAIN_CODES = {
    8'h35, 8'h1E, 8'h1F, 8'h20, 8'h21, 8'h22, 8'h23,
    8'h24, 8'h25, 8'h26, 8'h27, 8'h2D, 8'h2E, 8'h2A,
    8'h2B, 8'h14, 8'h1A, 8'h08, 8'h15, 8'h17, 8'h1C,
    8'h18, 8'h0C, 8'h12, 8'h13, 8'h2F, 8'h30, 8'h31,
    8'hF0, 8'h04, 8'h16, 8'h07, 8'h09, 8'h0A, 8'h0B,
    8'h0D, 8'h0E, 8'h0F, 8'h33, 8'h34, 8'h28, 8'h00,
    8'h00, 8'h1D, 8'h1B, 8'h06, 8'h19, 8'h05, 8'h11,
    8'h10, 8'h36, 8'h37, 8'h38, 8'h00, 8'h2C, 8'h00
  };
  localparam logic [0:55][7:0] FN_CODES = {
    8'h29, 8'h3A, 8'h3B, 8'h3C, 8'h3D, 8'h3E, 8'h3F,
    8'h40, 8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h4C,
    8'h00, 8'h00, 8'h52, 8'h00, 8'h00, 8'h00, 8'h4A,
    8'h4D, 8'h00, 8'h00, 8'h4B, 8'h00, 8'h00, 8'h00,
    8'hF0, 8'h50, 8'h51, 8'h4F, 8'h4E, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'hF1, 8'hF2, 8'hF3, 8'h00, 8'h00, 8'h00, 8'h00
  };

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_ready;
  kmeg_pkg::input_t    in_data = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  kmeg_pkg::result_t   out_data;
  logic                cfg_write = 1'b0;
  logic [1:0]          cfg_index = kmeg_pkg::REG_DEBOUNCE_INTERVAL;
  logic [15:0]         cfg_data = '0;

  key_matrix_event_generator dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Clock with a 20 ns period.
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Scanner state and configuration as the scoreboard sees them.
  logic [55:0] prev_matrix;
  logic [31:0] accept_stamp;
  logic        fn_down;
  logic [2:0]  mods_held;
  logic [7:0]  rpt_code;
  logic [31:0] rpt_start;
  logic [31:0] rpt_stamp;
  logic [15:0] debounce_len;
  logic        rpt_on;
  logic [15:0] delay_len;
  logic [15:0] period_ms;

  kmeg_pkg::input_t  pass_queue[$];
  kmeg_pkg::result_t expected_events[$];
  kmeg_pkg::result_t want;
  logic    in_fire = 1'b0;
  int      error_count = 0;
  int      tx_idle_pct = 20;
  int      rx_idle_pct = 20;
  int      hold_trigger = 0;
  int      hold_seen = 0;
  int      hold_left = 0;
  int      passes_queued = 0;
  int      passes_taken = 0;
  logic [31:0] stamp;
  logic [55:0] matrix;

  // Key code of one snapshot position; modifier keys have no code.
  function automatic logic [7:0] key_code_at(input int idx, input logic fn);
    logic [7:0] code;
    code = kmeg_pkg::CODE_NONE;
    if (idx != SHIFT_BIT && idx != CTRL_BIT && idx != ALT_BIT) begin
      if (fn && FN_CODES[idx] != kmeg_pkg::CODE_NONE) begin
        code = FN_CODES[idx];
      end else begin
        code = PLAIN_CODES[idx];
      end
    end
    return code;
  endfunction

  // Work out the events of one accepted polling pass and queue them.
  task automatic scan_pass(input kmeg_pkg::input_t pass);
    logic [55:0]       old_matrix;
    logic [31:0]       since_accept;
    logic [31:0]       since_start;
    logic [31:0]       since_repeat;
    logic [7:0]        code;
    logic              now_down;
    kmeg_pkg::result_t ev;
    kmeg_pkg::result_t batch[$];
    since_accept = pass.now_ms - accept_stamp;
    if (since_accept >= {16'd0, debounce_len}) begin
      old_matrix = prev_matrix;
      mods_held = {pass.key_matrix[ALT_BIT], pass.key_matrix[SHIFT_BIT],
                   pass.key_matrix[CTRL_BIT]};
      fn_down = pass.key_matrix[FN_BIT];
      for (int idx = 0; idx < kmeg_pkg::MATRIX_BITS; idx++) begin
        now_down = pass.key_matrix[idx];
        code = key_code_at(idx, fn_down);
        if (now_down != old_matrix[idx] && code != kmeg_pkg::CODE_NONE &&
            code != kmeg_pkg::CODE_FN) begin
          ev.key_code = code;
          ev.modifier_bits = mods_held;
          ev.is_press = now_down;
          ev.special_key = (code >= kmeg_pkg::CODE_SPECIAL);
          ev.last_of_run = 1'b0;
          batch.push_back(ev);
          if (now_down && rpt_on) begin
            rpt_code = code;
            rpt_start = pass.now_ms;
            rpt_stamp = '0;
          end else if (!now_down && code == rpt_code) begin
            rpt_code = kmeg_pkg::CODE_NONE;
          end
        end
      end
      prev_matrix = pass.key_matrix;
      accept_stamp = pass.now_ms;
    end

    // Auto-repeat of the last pressed key.
    since_start = pass.now_ms - rpt_start;
    since_repeat = pass.now_ms - rpt_stamp;
    if (rpt_on && rpt_code != kmeg_pkg::CODE_NONE && since_start >= {16'd0, delay_len}) begin
      if (rpt_stamp == 0 || since_repeat >= {16'd0, period_ms}) begin
        ev.key_code = rpt_code;
        ev.modifier_bits = mods_held;
        ev.is_press = 1'b1;
        ev.special_key = (rpt_code >= kmeg_pkg::CODE_SPECIAL);
        ev.last_of_run = 1'b0;
        batch.push_back(ev);
        rpt_stamp = pass.now_ms;
      end
    end

    for (int i = 0; i < batch.size(); i++) begin
      ev = batch[i];
      ev.last_of_run = (i == batch.size() - 1);
      expected_events.push_back(ev);
    end
  endtask

  // Input side: a new pass is offered once the previous one has transferred.
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_fire) begin
      if (pass_queue.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
        in_valid <= 1'b1;
        in_data <= pass_queue.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Output side: random back-pressure plus an occasional long hold-off.
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_seen != hold_trigger) begin
      hold_seen <= hold_trigger;
      hold_left <= LONG_HOLD;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Monitor: check each event transfer, then predict from each pass transfer.
  always @(posedge clk) begin
    if (rst) begin
      in_fire <= 1'b0;
    end else begin
      in_fire <= in_valid && in_ready;
      if (out_valid && out_ready) begin
        if (expected_events.size() == 0) begin
          $display("%0t: unexpected event, expected none, actual %h", $time, out_data);
          error_count++;
        end else begin
          want = expected_events.pop_front();
          if (out_data.key_code !== want.key_code ||
              out_data.modifier_bits !== want.modifier_bits ||
              out_data.is_press !== want.is_press ||
              out_data.special_key !== want.special_key ||
              out_data.last_of_run !== want.last_of_run) begin
            $display("%0t: event mismatch, expected code %h mods %b press %b special %b last %b",
                     $time, want.key_code, want.modifier_bits, want.is_press,
                     want.special_key, want.last_of_run);
            $display("%0t:                 actual code %h mods %b press %b special %b last %b",
                     $time, out_data.key_code, out_data.modifier_bits, out_data.is_press,
                     out_data.special_key, out_data.last_of_run);
            error_count++;
          end
        end
      end
      if (in_valid && in_ready) begin
        scan_pass(in_data);
        passes_taken++;
      end
    end
  end

  // Register write on the configuration port, mirrored into the scoreboard.
  task automatic write_setting(input logic [1:0] idx, input logic [15:0] value);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(negedge clk);
    cfg_write <= 1'b0;
    case (idx)
      kmeg_pkg::REG_DEBOUNCE_INTERVAL: debounce_len = value;
      kmeg_pkg::REG_REPEAT_ENABLE:     rpt_on = value[0];
      kmeg_pkg::REG_REPEAT_DELAY:      delay_len = value;
      kmeg_pkg::REG_REPEAT_PERIOD:     period_ms = value;
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic queue_pass(input logic [31:0] now, input logic [55:0] keys);
    kmeg_pkg::input_t item;
    item.now_ms = now;
    item.key_matrix = keys;
    pass_queue.push_back(item);
    passes_queued++;
  endtask

  // Wait until every pass has transferred and every event has arrived.
  task automatic drain_and_settle();
    while (passes_taken != passes_queued) @(negedge clk);
    while (expected_events.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Random passes: mostly a few keys changing, sometimes a whole new snapshot.
  task automatic queue_random_passes(input int count);
    logic [63:0] wide;
    int          pick;
    int          flips;
    int          bit_idx;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      if (pick < 60) begin
        stamp = stamp + $urandom_range(40);
      end else if (pick < 85) begin
        stamp = stamp + $urandom_range(1500);
      end else if (pick < 95) begin
        stamp = stamp + $urandom_range(70000, 60000);
      end else begin
        stamp = $urandom();
      end
      pick = $urandom_range(99);
      if (pick < 70) begin
        flips = $urandom_range(3, 1);
        for (int f = 0; f < flips; f++) begin
          case ($urandom_range(7))
            0: bit_idx = FN_BIT;
            1: bit_idx = SHIFT_BIT;
            2: bit_idx = CTRL_BIT;
            3: bit_idx = ALT_BIT;
            default: bit_idx = $urandom_range(kmeg_pkg::MATRIX_BITS - 1);
          endcase
          matrix[bit_idx] = ~matrix[bit_idx];
        end
      end else if (pick < 85) begin
        wide = {$urandom(), $urandom()};
        matrix = wide[55:0];
      end else if (pick < 92) begin
        matrix = '0;
      end else begin
        matrix = '1;
      end
      queue_pass(stamp, matrix);
    end
  endtask

  initial begin
    // Scoreboard starts from the reset state.
    prev_matrix = '0;
    accept_stamp = '0;
    fn_down = 1'b0;
    mods_held = '0;
    rpt_code = kmeg_pkg::CODE_NONE;
    rpt_start = '0;
    rpt_stamp = '0;
    debounce_len = kmeg_pkg::DEBOUNCE_RESET;
    rpt_on = 1'b1;
    delay_len = kmeg_pkg::DELAY_RESET;
    period_ms = kmeg_pkg::PERIOD_RESET;

    repeat (5) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed passes with the reset settings.
    queue_pass(32'd100, 56'd1 << 29);                  // press of a plain key
    queue_pass(32'd110, 56'd1 << 29);                  // too early, ignored
    queue_pass(32'd700, 56'd1 << 29);                  // first repeat
    queue_pass(32'd720, 56'd1 << 29);                  // inside the repeat period
    queue_pass(32'd760, 56'd1 << 29);                  // second repeat
    queue_pass(32'd800, 56'd0);                        // release clears repeat
    queue_pass(32'd900, (56'd1 << FN_BIT) | 56'd1);    // FN layer press
    queue_pass(32'd1000, (56'd1 << FN_BIT) | (56'd7 << 49)); // custom codes
    queue_pass(32'd1100, (56'd1 << SHIFT_BIT) | (56'd1 << CTRL_BIT) |
                         (56'd1 << ALT_BIT) | (56'd1 << 9));
    queue_pass(32'd1200, '1);                          // every key down
    queue_pass(32'd1300, '0);                          // every key up
    queue_pass(32'd1400, (56'd1 << FN_BIT) | (56'd1 << 14)); // empty FN entry
    queue_pass(32'd1500, 56'd1 << 41);                 // empty keymap entry
    queue_pass(32'hFFFF_FFF0, 56'd1 << 41);
    queue_pass(32'h0000_0004, '0);                     // elapsed time across wrap
    queue_pass(32'hFFFF_FC00, 56'd1 << 1);
    queue_pass(32'd0, 56'd1 << 1);                     // repeat stamped at zero
    queue_pass(32'd20, 56'd1 << 1);                    // repeats again
    queue_pass(32'd40, 56'd1 << 1);
    stamp = 32'd40;
    matrix = 56'd1 << 1;
    drain_and_settle();

    // No debounce, repeat disabled through a masked write.
    write_setting(kmeg_pkg::REG_DEBOUNCE_INTERVAL, 16'd0);
    write_setting(kmeg_pkg::REG_REPEAT_ENABLE, 16'hFFFE);
    write_setting(kmeg_pkg::REG_REPEAT_DELAY, 16'd0);
    write_setting(kmeg_pkg::REG_REPEAT_PERIOD, 16'd0);
    queue_random_passes(20);
    drain_and_settle();

    // Repeat enabled, with no delay and no period.
    write_setting(kmeg_pkg::REG_REPEAT_ENABLE, 16'd1);
    queue_random_passes(20);
    drain_and_settle();

    // Largest settings.
    write_setting(kmeg_pkg::REG_DEBOUNCE_INTERVAL, 16'hFFFF);
    write_setting(kmeg_pkg::REG_REPEAT_DELAY, 16'hFFFF);
    write_setting(kmeg_pkg::REG_REPEAT_PERIOD, 16'hFFFF);
    queue_random_passes(15);
    drain_and_settle();

    // Moderate random settings; the sender pauses halfway until all is out.
    write_setting(kmeg_pkg::REG_DEBOUNCE_INTERVAL, 16'($urandom_range(40)));
    write_setting(kmeg_pkg::REG_REPEAT_DELAY, 16'($urandom_range(300)));
    write_setting(kmeg_pkg::REG_REPEAT_PERIOD, 16'($urandom_range(100)));
    queue_random_passes(10);
    drain_and_settle();
    queue_random_passes(10);
    drain_and_settle();

    // No idling on either side, with one long receiver hold-off.
    write_setting(kmeg_pkg::REG_DEBOUNCE_INTERVAL, 16'd5);
    write_setting(kmeg_pkg::REG_REPEAT_DELAY, 16'd100);
    write_setting(kmeg_pkg::REG_REPEAT_PERIOD, 16'd20);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    hold_trigger = hold_trigger + 1;
    queue_random_passes(20);
    drain_and_settle();
    tx_idle_pct = 20;
    rx_idle_pct = 20;

    // Fully random settings.
    write_setting(kmeg_pkg::REG_DEBOUNCE_INTERVAL, 16'($urandom()));
    write_setting(kmeg_pkg::REG_REPEAT_ENABLE, 16'($urandom()));
    write_setting(kmeg_pkg::REG_REPEAT_DELAY, 16'($urandom()));
    write_setting(kmeg_pkg::REG_REPEAT_PERIOD, 16'($urandom()));
    queue_random_passes(20);
    drain_and_settle();

    if (error_count == 0 && expected_events.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Watchdog for a hung run.
  initial begin
    #(LIMIT_NS);
    $display("TEST FAILED");
    $finish;
  end

endmodule

>>> sim.f
hdl/kmeg_pkg.sv
hdl/kmeg_scan.sv
hdl/kmeg_outbuf.sv
hdl/key_matrix_event_generator.sv
dv/key_matrix_event_generator_test.sv
